### sv/ecpad_pkg.sv
package ecpad_pkg;

    localparam int FIELD_BITS = 31;
    localparam int CNT_W      = $clog2(FIELD_BITS);
    localparam int PC_W       = 6;

    // Config register indexes
    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_CURVE_A = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [FIELD_BITS-1:0] first_x;
        logic [FIELD_BITS-1:0] first_y;
        logic [FIELD_BITS-1:0] second_x;
        logic [FIELD_BITS-1:0] second_y;
    } t_in;

    typedef struct packed {
        logic [FIELD_BITS-1:0] result_x;
        logic [FIELD_BITS-1:0] result_y;
    } t_out;

    // Register file entries; the last three are read-only sources.
    typedef enum logic [4:0] {
        R_X1   = 5'd0,
        R_Y1   = 5'd1,
        R_X2   = 5'd2,
        R_Y2   = 5'd3,
        R_A    = 5'd4,
        R_T0   = 5'd5,
        R_T1   = 5'd6,
        R_S    = 5'd7,
        R_X3   = 5'd8,
        R_Y3   = 5'd9,
        R_RP   = 5'd10,
        R_RC   = 5'd11,
        R_TP   = 5'd12,
        R_TC   = 5'd13,
        R_Q    = 5'd14,
        R_TMP  = 5'd15,
        R_ONE  = 5'd16,
        R_ZERO = 5'd17,
        R_P    = 5'd18
    } t_reg;

    typedef enum logic [3:0] {
        OP_MOV    = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MUL    = 4'd3,
        OP_DIV    = 4'd4,
        OP_JSMALL = 4'd5,
        OP_JADD   = 4'd6,
        OP_JRCZ   = 4'd7,
        OP_JMP    = 4'd8,
        OP_OUT    = 4'd9
    } t_op;

    typedef struct packed {
        logic load;
        logic issue;
        t_op  op;
        t_reg dst;
        t_reg sa;
        t_reg sb;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic p_small;
        logic add_mode;
        logic rc_zero;
        logic unit_done;
        logic out_busy;
    } t_status;

endpackage

### sv/ec_point_add_double_mod_p_top.sv
// Affine point add / double over GF(p), p and a set through the config port.
// Input channel: i_valid / o_stall carry one transaction of type t_in
// (mode, first point, second point). mode 0 adds, mode 1 doubles the first.
// Output channel: o_valid / i_stall carry one t_out transaction per input.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 = modulus p, 1 = curve a); write only while the block is idle.
// One transaction is worked on at a time; o_stall is high from acceptance
// until the result is loaded into the output register.
// The number of extended Euclid steps (at most about 45 for 31-bit
// operands) adds to the time a transaction takes. The bit-serial modular
// multiplier and divider share one unit; no new transaction is taken
// until the last result is loaded into the output register.
// Reset (synchronous, active low) sets p = 3, a = 0, empties the output.
// When the receiver stalls, the result holds in the output register; a new
// transaction is still accepted and computed, and waits only at its own
// output load until the older result has been taken.
module ec_point_add_double_mod_p_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  ecpad_pkg::t_in                   i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output ecpad_pkg::t_out                  o_data,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [ecpad_pkg::FIELD_BITS-1:0] i_cfg_data
);

    logic [ecpad_pkg::FIELD_BITS-1:0] r_p;
    logic [ecpad_pkg::FIELD_BITS-1:0] r_a;
    logic                             idle;
    logic                             start;
    ecpad_pkg::t_cmd                  cmd;
    ecpad_pkg::t_status               status;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= ecpad_pkg::FIELD_BITS'(3);
            r_a <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ecpad_pkg::CFG_MODULUS: r_p <= i_cfg_data;
                ecpad_pkg::CFG_CURVE_A: r_a <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = !idle;
    assign start   = i_valid && idle;

    ecpad_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_idle   (idle),
        .o_cmd    (cmd)
    );

    ecpad_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (i_data),
        .i_p      (r_p),
        .i_a      (r_a),
        .i_stall  (i_stall),
        .o_status (status),
        .o_valid  (o_valid),
        .o_data   (o_data)
    );

endmodule

### sv/ecpad_ctrl.sv
module ecpad_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ecpad_pkg::t_status i_status,
    output logic               o_idle,
    output ecpad_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT
    } t_state;

    typedef struct packed {
        ecpad_pkg::t_op                 op;
        ecpad_pkg::t_reg                dst;
        ecpad_pkg::t_reg                sa;
        ecpad_pkg::t_reg                sb;
        logic [ecpad_pkg::PC_W-1:0]     tgt;
    } t_uop;

    localparam logic [ecpad_pkg::PC_W-1:0] L_ADD   = 6'd14;
    localparam logic [ecpad_pkg::PC_W-1:0] L_INV   = 6'd16;
    localparam logic [ecpad_pkg::PC_W-1:0] L_LOOP  = 6'd20;
    localparam logic [ecpad_pkg::PC_W-1:0] L_FIN   = 6'd27;
    localparam logic [ecpad_pkg::PC_W-1:0] L_SMALL = 6'd35;
    localparam logic [ecpad_pkg::PC_W-1:0] L_NONE  = 6'd0;

    function automatic t_uop mk(input ecpad_pkg::t_op op, input ecpad_pkg::t_reg dst,
                                input ecpad_pkg::t_reg sa, input ecpad_pkg::t_reg sb,
                                input logic [ecpad_pkg::PC_W-1:0] tgt);
        t_uop u;
        u.op  = op;
        u.dst = dst;
        u.sa  = sa;
        u.sb  = sb;
        u.tgt = tgt;
        return u;
    endfunction

    // Microprogram: reduce inputs, form slope numerator/denominator,
    // extended Euclid inverse, x3/y3 formulas; zero result if p < 2.
    function automatic t_uop ucode(input logic [ecpad_pkg::PC_W-1:0] pc);
        t_uop u;
        u = mk(ecpad_pkg::OP_JMP, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO, ecpad_pkg::R_ZERO,
               L_SMALL);
        unique case (pc)
            6'd0:  u = mk(ecpad_pkg::OP_JSMALL, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_SMALL);
            6'd1:  u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_X1, ecpad_pkg::R_X1,
                          ecpad_pkg::R_ONE, L_NONE);
            6'd2:  u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_Y1, ecpad_pkg::R_Y1,
                          ecpad_pkg::R_ONE, L_NONE);
            6'd3:  u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_X2, ecpad_pkg::R_X2,
                          ecpad_pkg::R_ONE, L_NONE);
            6'd4:  u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_Y2, ecpad_pkg::R_Y2,
                          ecpad_pkg::R_ONE, L_NONE);
            6'd5:  u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_A, ecpad_pkg::R_A,
                          ecpad_pkg::R_ONE, L_NONE);
            6'd6:  u = mk(ecpad_pkg::OP_JADD, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_ADD);
            6'd7:  u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_X2, ecpad_pkg::R_X1,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd8:  u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_T0, ecpad_pkg::R_X1,
                          ecpad_pkg::R_X1, L_NONE);
            6'd9:  u = mk(ecpad_pkg::OP_ADD, ecpad_pkg::R_TMP, ecpad_pkg::R_T0,
                          ecpad_pkg::R_T0, L_NONE);
            6'd10: u = mk(ecpad_pkg::OP_ADD, ecpad_pkg::R_T0, ecpad_pkg::R_TMP,
                          ecpad_pkg::R_T0, L_NONE);
            6'd11: u = mk(ecpad_pkg::OP_ADD, ecpad_pkg::R_T0, ecpad_pkg::R_T0,
                          ecpad_pkg::R_A, L_NONE);
            6'd12: u = mk(ecpad_pkg::OP_ADD, ecpad_pkg::R_T1, ecpad_pkg::R_Y1,
                          ecpad_pkg::R_Y1, L_NONE);
            6'd13: u = mk(ecpad_pkg::OP_JMP, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_INV);
            6'd14: u = mk(ecpad_pkg::OP_SUB, ecpad_pkg::R_T0, ecpad_pkg::R_Y2,
                          ecpad_pkg::R_Y1, L_NONE);
            6'd15: u = mk(ecpad_pkg::OP_SUB, ecpad_pkg::R_T1, ecpad_pkg::R_X2,
                          ecpad_pkg::R_X1, L_NONE);
            6'd16: u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_RP, ecpad_pkg::R_P,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd17: u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_RC, ecpad_pkg::R_T1,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd18: u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_TP, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd19: u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_TC, ecpad_pkg::R_ONE,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd20: u = mk(ecpad_pkg::OP_JRCZ, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_FIN);
            6'd21: u = mk(ecpad_pkg::OP_DIV, ecpad_pkg::R_Q, ecpad_pkg::R_RP,
                          ecpad_pkg::R_RC, L_NONE);
            6'd22: u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_TMP, ecpad_pkg::R_Q,
                          ecpad_pkg::R_TC, L_NONE);
            6'd23: u = mk(ecpad_pkg::OP_SUB, ecpad_pkg::R_TMP, ecpad_pkg::R_TP,
                          ecpad_pkg::R_TMP, L_NONE);
            6'd24: u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_TP, ecpad_pkg::R_TC,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd25: u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_TC, ecpad_pkg::R_TMP,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd26: u = mk(ecpad_pkg::OP_JMP, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_LOOP);
            6'd27: u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_S, ecpad_pkg::R_T0,
                          ecpad_pkg::R_TP, L_NONE);
            6'd28: u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_TMP, ecpad_pkg::R_S,
                          ecpad_pkg::R_S, L_NONE);
            6'd29: u = mk(ecpad_pkg::OP_SUB, ecpad_pkg::R_TMP, ecpad_pkg::R_TMP,
                          ecpad_pkg::R_X1, L_NONE);
            6'd30: u = mk(ecpad_pkg::OP_SUB, ecpad_pkg::R_X3, ecpad_pkg::R_TMP,
                          ecpad_pkg::R_X2, L_NONE);
            6'd31: u = mk(ecpad_pkg::OP_SUB, ecpad_pkg::R_TMP, ecpad_pkg::R_X1,
                          ecpad_pkg::R_X3, L_NONE);
            6'd32: u = mk(ecpad_pkg::OP_MUL, ecpad_pkg::R_TMP, ecpad_pkg::R_S,
                          ecpad_pkg::R_TMP, L_NONE);
            6'd33: u = mk(ecpad_pkg::OP_SUB, ecpad_pkg::R_Y3, ecpad_pkg::R_TMP,
                          ecpad_pkg::R_Y1, L_NONE);
            6'd34: u = mk(ecpad_pkg::OP_OUT, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd35: u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_X3, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd36: u = mk(ecpad_pkg::OP_MOV, ecpad_pkg::R_Y3, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_NONE);
            6'd37: u = mk(ecpad_pkg::OP_OUT, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO,
                          ecpad_pkg::R_ZERO, L_NONE);
            default: u = mk(ecpad_pkg::OP_JMP, ecpad_pkg::R_TMP, ecpad_pkg::R_ZERO,
                            ecpad_pkg::R_ZERO, L_SMALL);
        endcase
        return u;
    endfunction

    t_state                     r_state;
    logic [ecpad_pkg::PC_W-1:0] r_pc;
    t_uop                       uop;
    logic                       take_jump;

    assign uop = ucode(r_pc);

    always_comb begin
        unique case (uop.op)
            ecpad_pkg::OP_JSMALL: take_jump = i_status.p_small;
            ecpad_pkg::OP_JADD:   take_jump = i_status.add_mode;
            ecpad_pkg::OP_JRCZ:   take_jump = i_status.rc_zero;
            ecpad_pkg::OP_JMP:    take_jump = 1'b1;
            default:              take_jump = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_EXEC;
                        r_pc    <= '0;
                    end
                end
                ST_EXEC: begin
                    unique case (uop.op)
                        ecpad_pkg::OP_MUL, ecpad_pkg::OP_DIV: begin
                            r_state <= ST_WAIT;
                        end
                        ecpad_pkg::OP_OUT: begin
                            if (!i_status.out_busy) r_state <= ST_IDLE;
                        end
                        ecpad_pkg::OP_JSMALL, ecpad_pkg::OP_JADD,
                        ecpad_pkg::OP_JRCZ, ecpad_pkg::OP_JMP: begin
                            r_pc <= take_jump ? uop.tgt : r_pc + 1'b1;
                        end
                        default: r_pc <= r_pc + 1'b1;
                    endcase
                end
                ST_WAIT: begin
                    if (i_status.unit_done) begin
                        r_state <= ST_EXEC;
                        r_pc    <= r_pc + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.load     = (r_state == ST_IDLE) && i_start;
        o_cmd.issue    = (r_state == ST_EXEC) &&
                         (uop.op == ecpad_pkg::OP_MOV || uop.op == ecpad_pkg::OP_ADD ||
                          uop.op == ecpad_pkg::OP_SUB || uop.op == ecpad_pkg::OP_MUL ||
                          uop.op == ecpad_pkg::OP_DIV);
        o_cmd.op       = uop.op;
        o_cmd.dst      = uop.dst;
        o_cmd.sa       = uop.sa;
        o_cmd.sb       = uop.sb;
        o_cmd.out_load = (r_state == ST_EXEC) && (uop.op == ecpad_pkg::OP_OUT) &&
                         !i_status.out_busy;
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

### sv/ecpad_dp.sv
module ecpad_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ecpad_pkg::t_cmd                  i_cmd,
    input  ecpad_pkg::t_in                   i_in,
    input  logic [ecpad_pkg::FIELD_BITS-1:0] i_p,
    input  logic [ecpad_pkg::FIELD_BITS-1:0] i_a,
    input  logic                             i_stall,
    output ecpad_pkg::t_status               o_status,
    output logic                             o_valid,
    output ecpad_pkg::t_out                  o_data
);

    localparam int FB = ecpad_pkg::FIELD_BITS;

    logic [FB-1:0]               r_rf [16];
    logic                        r_mode;
    logic                        r_busy;
    logic                        r_div;
    logic [ecpad_pkg::CNT_W-1:0] r_cnt;
    logic [FB-1:0]               r_ma;   // multiplier bits / dividend-quotient
    logic [FB-1:0]               r_mb;   // multiplicand / divisor
    logic [FB-1:0]               r_acc;  // product acc / partial remainder
    ecpad_pkg::t_reg             r_dst;
    logic                        r_out_valid;
    ecpad_pkg::t_out             r_out;

    function automatic logic [FB-1:0] rd(input ecpad_pkg::t_reg sel,
                                         input logic [FB-1:0] p);
        logic [FB-1:0] v;
        unique case (sel)
            ecpad_pkg::R_ONE:  v = FB'(1);
            ecpad_pkg::R_ZERO: v = '0;
            ecpad_pkg::R_P:    v = p;
            default:           v = r_rf[sel[3:0]];
        endcase
        return v;
    endfunction

    logic [FB-1:0] va, vb, add_res, sub_res, mul_next, div_rem, div_q;
    logic [FB:0]   p_ext, sum, dif, dbl, rem;
    logic          qbit, done;

    assign p_ext = {1'b0, i_p};
    assign done  = r_busy && (r_cnt == '0);

    always_comb begin
        va = rd(i_cmd.sa, i_p);
        vb = rd(i_cmd.sb, i_p);
    end

    always_comb begin
        sum = {1'b0, va} + {1'b0, vb};
        if (sum >= p_ext) sum = sum - p_ext;
        add_res = sum[FB-1:0];

        dif = {1'b0, va} + p_ext - {1'b0, vb};
        if (dif >= p_ext) dif = dif - p_ext;
        sub_res = dif[FB-1:0];

        // interleaved shift-add modular multiply, MSB first
        dbl = {r_acc, 1'b0};
        if (dbl >= p_ext) dbl = dbl - p_ext;
        if (r_ma[FB-1]) dbl = dbl + {1'b0, r_mb};
        if (dbl >= p_ext) dbl = dbl - p_ext;
        mul_next = dbl[FB-1:0];

        // restoring division, one quotient bit per cycle
        rem  = {r_acc, r_ma[FB-1]};
        qbit = (rem >= {1'b0, r_mb});
        if (qbit) rem = rem - {1'b0, r_mb};
        div_rem = rem[FB-1:0];
        div_q   = {r_ma[FB-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_div       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            if (i_cmd.out_load) r_out_valid <= 1'b1;

            if (i_cmd.issue && (i_cmd.op == ecpad_pkg::OP_MUL ||
                                i_cmd.op == ecpad_pkg::OP_DIV)) begin
                r_busy <= 1'b1;
                r_div  <= (i_cmd.op == ecpad_pkg::OP_DIV);
                r_cnt  <= ecpad_pkg::CNT_W'(FB - 1);
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode                     <= i_in.mode;
            r_rf[ecpad_pkg::R_X1[3:0]] <= i_in.first_x;
            r_rf[ecpad_pkg::R_Y1[3:0]] <= i_in.first_y;
            r_rf[ecpad_pkg::R_X2[3:0]] <= i_in.second_x;
            r_rf[ecpad_pkg::R_Y2[3:0]] <= i_in.second_y;
            r_rf[ecpad_pkg::R_A[3:0]]  <= i_a;
        end
        if (i_cmd.issue) begin
            unique case (i_cmd.op)
                ecpad_pkg::OP_MOV: r_rf[i_cmd.dst[3:0]] <= va;
                ecpad_pkg::OP_ADD: r_rf[i_cmd.dst[3:0]] <= add_res;
                ecpad_pkg::OP_SUB: r_rf[i_cmd.dst[3:0]] <= sub_res;
                ecpad_pkg::OP_MUL, ecpad_pkg::OP_DIV: begin
                    r_ma  <= va;
                    r_mb  <= vb;
                    r_acc <= '0;
                    r_dst <= i_cmd.dst;
                end
                default: ;
            endcase
        end
        if (r_busy) begin
            r_acc <= r_div ? div_rem : mul_next;
            r_ma  <= r_div ? div_q : {r_ma[FB-2:0], 1'b0};
        end
        if (done) begin
            if (r_div) begin
                r_rf[ecpad_pkg::R_Q[3:0]]  <= div_q;
                r_rf[ecpad_pkg::R_RP[3:0]] <= r_mb;
                r_rf[ecpad_pkg::R_RC[3:0]] <= div_rem;
            end else begin
                r_rf[r_dst[3:0]] <= mul_next;
            end
        end
        if (i_cmd.out_load) begin
            r_out.result_x <= r_rf[ecpad_pkg::R_X3[3:0]];
            r_out.result_y <= r_rf[ecpad_pkg::R_Y3[3:0]];
        end
    end

    always_comb begin
        o_status.p_small   = (i_p < FB'(2));
        o_status.add_mode  = !r_mode;
        o_status.rc_zero   = (r_rf[ecpad_pkg::R_RC[3:0]] == '0);
        o_status.unit_done = done;
        o_status.out_busy  = r_out_valid && i_stall;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### verif/ec_point_add_double_mod_p_top_test.sv
module ec_point_add_double_mod_p_top_test;

    localparam int   FB = ecpad_pkg::FIELD_BITS;
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;
    localparam int   MAX_IDLE_CYCLES = 200000;
    localparam int   DRAIN_CYCLES    = 3600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    ecpad_pkg::t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    ecpad_pkg::t_out o_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [FB-1:0] i_cfg_data = '0;

    ec_point_add_double_mod_p_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: its own copy of the configuration
    logic [63:0] field_p = 3;
    logic [63:0] coef_a = 0;

    ecpad_pkg::t_in  pending_points[$];
    ecpad_pkg::t_out expected_points[$];
    int   fail_count = 0;
    int   idle_cycles = 0;
    bit   sender_busy_gaps = 1'b1;
    bit   receiver_busy_gaps = 1'b1;
    bit   send_enable = 1'b0;
    int   hold_off_cycles = 0;

    function automatic logic [63:0] inverse_mod(logic [63:0] v, logic [63:0] m);
        logic [63:0] r_prev, r_cur, t_prev, t_cur, q, r_next, prod, t_next;
        r_prev = m;
        r_cur = v % m;
        t_prev = 0;
        t_cur = 1 % m;
        while (r_cur != 0) begin
            q = r_prev / r_cur;
            r_next = r_prev - q * r_cur;
            prod = ((q % m) * t_cur) % m;
            t_next = (t_prev + m - prod) % m;
            r_prev = r_cur;
            r_cur = r_next;
            t_prev = t_cur;
            t_cur = t_next;
        end
        return t_prev % m;
    endfunction

    function automatic ecpad_pkg::t_out point_op(ecpad_pkg::t_in t);
        logic [63:0] p, x1, y1, x2, y2, a, num, den, s, x3, y3, tmp;
        ecpad_pkg::t_out r;
        p = field_p;
        r = '0;
        if (p < 2) return r;
        x1 = t.first_x % p;
        y1 = t.first_y % p;
        x2 = t.second_x % p;
        y2 = t.second_y % p;
        a = coef_a % p;
        if (t.mode == MODE_DOUBLE) begin
            x2 = x1;
            num = ((3 * ((x1 * x1) % p)) % p + a) % p;
            den = (2 * y1) % p;
        end else begin
            num = (y2 + p - y1) % p;
            den = (x2 + p - x1) % p;
        end
        s = (num * inverse_mod(den, p)) % p;
        tmp = (s * s) % p;
        tmp = (tmp + p - x1) % p;
        x3 = (tmp + p - x2) % p;
        tmp = (s * ((x1 + p - x3) % p)) % p;
        y3 = (tmp + p - y1) % p;
        r.result_x = x3[FB-1:0];
        r.result_y = y3[FB-1:0];
        return r;
    endfunction

    // Driver: offers queued transactions; valid independent of stall
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            expected_points.push_back(point_op(i_data));
            void'(pending_points.pop_front());
        end
        if (i_valid && o_stall) begin
            // stalled: hold valid and payload
        end else if (!send_enable || pending_points.size() == 0) begin
            i_valid <= 1'b0;
        end else if (sender_busy_gaps && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
        end else begin
            i_valid <= 1'b1;
            i_data <= pending_points[0];
        end
    end

    // Monitor plus receiver stall
    always @(posedge i_clk) begin
        ecpad_pkg::t_out want;
        if (o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", o_data.result_x, o_data.result_y);
                fail_count++;
            end else begin
                want = expected_points.pop_front();
                if (o_data.result_x !== want.result_x) begin
                    $error("result_x expected %0d actual %0d", want.result_x, o_data.result_x);
                    fail_count++;
                end
                if (o_data.result_y !== want.result_y) begin
                    $error("result_y expected %0d actual %0d", want.result_y, o_data.result_y);
                    fail_count++;
                end
            end
        end
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= receiver_busy_gaps && ($urandom_range(99) < 33);
        end
    end

    // Watchdog: cycles without any accepted transaction or delivered result
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > MAX_IDLE_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [FB-1:0] rand_field(logic [63:0] m);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return (m > 0) ? FB'(m - 1) : '0;
            3: return FB'($urandom);
            default: return (m > 0) ? FB'({$urandom} % m) : FB'($urandom);
        endcase
    endfunction

    function automatic ecpad_pkg::t_in rand_point(logic [63:0] m);
        ecpad_pkg::t_in t;
        t.mode = 1'($urandom_range(1));
        t.first_x = rand_field(m);
        t.first_y = rand_field(m);
        t.second_x = ($urandom_range(9) == 0) ? t.first_x : rand_field(m);
        t.second_y = rand_field(m);
        return t;
    endfunction

    task automatic write_cfg(logic idx, logic [FB-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ecpad_pkg::CFG_MODULUS) field_p = val;
        else coef_a = val;
    endtask

    // Wait for every queued and expected transaction, then a further DRAIN_CYCLES wait
    task automatic drain_all();
        while (pending_points.size() != 0 || expected_points.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_point(logic m, int x1, int y1, int x2, int y2);
        ecpad_pkg::t_in t;
        t.mode = m;
        t.first_x = FB'(x1);
        t.first_y = FB'(y1);
        t.second_x = FB'(x2);
        t.second_y = FB'(y2);
        pending_points.push_back(t);
    endtask

    logic [FB-1:0] moduli [6] = '{31'd2147483647, 31'd97, 31'd3,
                                  31'd1000000007, 31'd15, 31'd65521};
    logic [FB-1:0] coefs [6] = '{31'd2147483646, 31'd2, 31'd0,
                                 31'd0, 31'd7, 31'h7fffffff};

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_enable = 1'b1;

        // Directed: reset config (p=3, a=0)
        add_point(MODE_ADD, 1, 1, 2, 0);
        add_point(MODE_DOUBLE, 1, 1, 0, 0);
        drain_all();
        write_cfg(ecpad_pkg::CFG_MODULUS, 31'd2147483647);
        write_cfg(ecpad_pkg::CFG_CURVE_A, 31'd2147483646);
        add_point(MODE_ADD, 0, 0, 2147483646, 2147483646);
        add_point(MODE_DOUBLE, 2147483646, 2147483646, 0, 0);
        add_point(MODE_ADD, 5, 7, 5, 9);               // equal x: zero slope
        add_point(MODE_DOUBLE, 12345, 0, 1, 1);         // y1 zero: zero slope
        add_point(MODE_ADD, 31'h7fffffff, 31'h7fffffff, 3, 4); // equal to p
        add_point(MODE_DOUBLE, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        add_point(MODE_ADD, 1, 2, 3, 4);
        drain_all();
        write_cfg(ecpad_pkg::CFG_MODULUS, 31'd0);       // degenerate moduli
        add_point(MODE_ADD, 1, 2, 3, 4);
        drain_all();
        write_cfg(ecpad_pkg::CFG_MODULUS, 31'd1);
        add_point(MODE_DOUBLE, 1, 2, 3, 4);
        drain_all();
        write_cfg(ecpad_pkg::CFG_MODULUS, 31'd21);      // composite modulus
        write_cfg(ecpad_pkg::CFG_CURVE_A, 31'd40);
        add_point(MODE_ADD, 3, 1, 6, 2);
        add_point(MODE_DOUBLE, 4, 3, 0, 0);
        add_point(MODE_ADD, 20, 20, 0, 0);
        drain_all();

        // Random phases over several configurations
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(ecpad_pkg::CFG_MODULUS, moduli[ph]);
            write_cfg(ecpad_pkg::CFG_CURVE_A, coefs[ph]);
            sender_busy_gaps = (ph != 2);
            receiver_busy_gaps = (ph != 2);
            for (int n = 0; n < 320; n++) pending_points.push_back(rand_point(field_p));
            if (ph == 3) begin
                // long receiver hold-off while the sender keeps offering
                wait (expected_points.size() > 0);
                hold_off_cycles = 8000;
            end
            if (ph == 1) begin
                // sender pauses until all results are back
                wait (pending_points.size() < 160);
                send_enable = 1'b0;
                wait (expected_points.size() == 0 && !i_valid);
                send_enable = 1'b1;
            end
            drain_all();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
